// File: src/spc_pkg.sv
// Shared types and constants for the sensitive path classifier.
// Holds the prefix and suffix pattern tables, class codes and the scan flag struct.
// No dependencies.
`default_nettype none

package spc_pkg;

  localparam int WIN_DEPTH       = 22;
  localparam int PREFIX_DEPTH    = 24;
  localparam int N_PREFIX        = 11;
  localparam int PID_SLASH_FIRST = 7;
  localparam int PID_SLASH_LAST  = 18;
  localparam int WANTS_MIN_KEPT  = 29;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef logic [WIN_DEPTH-1:0][7:0]    window_t;
  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_text_t;

  localparam int PX_PROC    = 0;
  localparam int PX_CRON    = 1;
  localparam int PX_ATJOBS  = 2;
  localparam int PX_ATSPOOL = 3;
  localparam int PX_AT      = 4;
  localparam int PX_ETCSYS  = 5;
  localparam int PX_LIBSYS  = 6;
  localparam int PX_USRSYS  = 7;
  localparam int PX_SUDO    = 8;
  localparam int PX_SHADOW  = 9;
  localparam int PX_PASSWD  = 10;

  // Text is right-justified, so character j of a prefix of length L sits in entry L-1-j.
  localparam prefix_text_t PX_TEXT [N_PREFIX] = '{
    "/proc/",
    "/etc/cron",
    "/var/spool/cron/atjobs/",
    "/var/spool/cron/atspool/",
    "/var/spool/at/",
    "/etc/systemd/system/",
    "/lib/systemd/system/",
    "/usr/lib/systemd/system/",
    "/etc/sudoers",
    "/etc/shadow",
    "/etc/passwd"
  };

  localparam int PX_LEN [N_PREFIX] = '{6, 9, 23, 24, 14, 20, 20, 24, 12, 11, 11};

  // Suffix patterns: entry k matches window entry k, the newest character being entry 0.
  localparam window_t SFX_TIMER = ".timer";
  localparam window_t SFX_MEM   = "/mem";
  localparam window_t SFX_MAPS  = "/maps";
  localparam window_t SFX_USER  = "/.config/systemd/user/";
  localparam window_t SFX_WANTS = "timers.target.wants/";

  localparam int LEN_TIMER = 6;
  localparam int LEN_MEM   = 4;
  localparam int LEN_MAPS  = 5;
  localparam int LEN_USER  = 22;
  localparam int LEN_WANTS = 20;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_MAPS = 3'd1,
    KIND_MEM  = 3'd2,
    KIND_CRON = 3'd3,
    KIND_AT   = 3'd4
  } kind_t;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_SEEN1  = 7'b0000010,
    PH_SEEN2  = 7'b0000100,
    PH_SEEN3  = 7'b0001000,
    PH_SEEN4  = 7'b0010000,
    PH_MAPS   = 7'b0100000,
    PH_DEAD   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [N_PREFIX-1:0] alive;
    phase_t              phase;
    logic                user_seen;
    logic                wants_seen;
  } scan_flags_t;

  // True if the newest len window entries spell the pattern.
  function automatic logic tail_match(window_t w, window_t pat, int len);
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (k < len && w[k] != pat[k]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: src/spc_classify.sv
// Final classification of a finished path from the scan state.
// Depends on spc_pkg for the pattern tables, flag struct and class codes.
`default_nettype none

module spc_classify
  import spc_pkg::*;
#(
  parameter int CW = 6
) (
  input  wire logic [CW-1:0] count,
  input  wire window_t       win,
  input  wire scan_flags_t   flags,
  output kind_t              kind
);

  logic [N_PREFIX-1:0] px_hit;
  logic                proc_ok;
  logic                timer;
  logic                mem_tail;
  logic                unit;
  logic [31:0]         cnt;

  always_comb begin
    cnt = 32'(count);
    for (int i = 0; i < N_PREFIX; i++) begin
      px_hit[i] = flags.alive[i] && (cnt >= 32'(PX_LEN[i]));
    end
    proc_ok  = px_hit[PX_PROC];
    timer    = (cnt >= 32'(LEN_TIMER)) && tail_match(win, SFX_TIMER, LEN_TIMER);
    mem_tail = (cnt >= 32'(LEN_MEM)) && tail_match(win, SFX_MEM, LEN_MEM);
    unit     = px_hit[PX_ETCSYS] || px_hit[PX_LIBSYS] || px_hit[PX_USRSYS] ||
               flags.user_seen || (flags.wants_seen && cnt >= 32'(WANTS_MIN_KEPT));

    if (proc_ok && flags.phase == PH_MAPS) begin
      kind = KIND_MAPS;
    end else if (proc_ok && flags.phase == PH_SEEN4 && mem_tail) begin
      kind = KIND_MEM;
    end else if (px_hit[PX_ATJOBS] || px_hit[PX_ATSPOOL] || px_hit[PX_AT]) begin
      kind = KIND_AT;
    end else if (px_hit[PX_CRON] || (timer && unit) || px_hit[PX_SUDO] ||
                 px_hit[PX_SHADOW] || px_hit[PX_PASSWD]) begin
      kind = KIND_CRON;
    end else begin
      kind = KIND_NONE;
    end
  end

endmodule

`default_nettype wire

// File: src/sensitive_path_classifier.sv
// A terminating byte is held in the input byte register, and its classification is
// then written into the result register once that register is free to take it.
// Throughput: one path byte per cycle, unless a terminating byte waits for a stalled
// result; the scan state is updated by a single pass between the input byte register
// and the result register. Reset: synchronous active-low rst_n empties both registers
// and clears the scan state; the block can take a byte as soon as rst_n is deasserted.
// Depends on spc_pkg and spc_classify.
`default_nettype none

module sensitive_path_classifier
  import spc_pkg::*;
#(
  parameter int MAX_NAME_CHARS        = 63,
  parameter int SUBSTRING_START_LIMIT = 40
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_path_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_match_kind,
  output logic [5:0]      out_name_length
);

  localparam int CW = $clog2(MAX_NAME_CHARS + 1);

  logic          byte_vld_r, byte_vld_nxt;
  logic [7:0]    byte_r;
  logic [CW-1:0] count_r, count_nxt;
  window_t       win_r, win_nxt;
  scan_flags_t   flags_r, flags_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r;
  logic [5:0]    out_len_r;

  logic          is_term;
  logic          out_free;
  logic          consume;
  kind_t         kind;
  logic [31:0]   pos;
  logic [31:0]   cnt_new;
  logic [4:0]    px_idx;
  window_t       win_shift;

  spc_classify #(
    .CW(CW)
  ) u_classify (
    .count(count_r),
    .win  (win_r),
    .flags(flags_r),
    .kind (kind)
  );

  assign is_term  = (byte_r == CHAR_NUL);
  assign out_free = !out_valid_r || !out_stall;
  assign consume  = byte_vld_r && (!is_term || out_free);
  assign in_stall = byte_vld_r && !consume;

  always_comb begin
    count_nxt = count_r;
    win_nxt   = win_r;
    flags_nxt = flags_r;
    pos       = 32'(count_r);
    cnt_new   = pos + 32'd1;
    win_shift = {win_r[WIN_DEPTH-2:0], byte_r};
    px_idx    = '0;
    if (consume) begin
      if (is_term) begin
        count_nxt  = '0;
        flags_nxt.alive      = '1;
        flags_nxt.phase      = PH_SEARCH;
        flags_nxt.user_seen  = 1'b0;
        flags_nxt.wants_seen = 1'b0;
      end else if (pos < 32'(MAX_NAME_CHARS)) begin
        win_nxt   = win_shift;
        count_nxt = count_r + CW'(1);
        for (int i = 0; i < N_PREFIX; i++) begin
          px_idx = 5'(PX_LEN[i] - 1 - int'(pos[7:0]));
          if (pos < 32'(PX_LEN[i]) && PX_TEXT[i][px_idx] != byte_r) begin
            flags_nxt.alive[i] = 1'b0;
          end
        end
        case (flags_r.phase)
          PH_SEARCH: begin
            if (pos inside {[PID_SLASH_FIRST:PID_SLASH_LAST]} && byte_r == CHAR_SLASH) begin
              flags_nxt.phase = PH_SEEN1;
            end else if (pos >= 32'(PID_SLASH_LAST)) begin
              flags_nxt.phase = PH_DEAD;
            end
          end
          PH_SEEN1: flags_nxt.phase = PH_SEEN2;
          PH_SEEN2: flags_nxt.phase = PH_SEEN3;
          PH_SEEN3: flags_nxt.phase = PH_SEEN4;
          PH_SEEN4: begin
            if (tail_match(win_shift, SFX_MAPS, LEN_MAPS)) begin
              flags_nxt.phase = PH_MAPS;
            end else begin
              flags_nxt.phase = PH_DEAD;
            end
          end
          default: flags_nxt.phase = flags_r.phase;
        endcase
        if (cnt_new >= 32'(LEN_USER) &&
            cnt_new <= 32'(SUBSTRING_START_LIMIT + LEN_USER) &&
            tail_match(win_shift, SFX_USER, LEN_USER)) begin
          flags_nxt.user_seen = 1'b1;
        end
        if (cnt_new >= 32'(LEN_WANTS) &&
            cnt_new <= 32'(SUBSTRING_START_LIMIT + LEN_WANTS) &&
            tail_match(win_shift, SFX_WANTS, LEN_WANTS)) begin
          flags_nxt.wants_seen = 1'b1;
        end
      end
    end
  end

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_valid && !in_stall) begin
      byte_vld_nxt = 1'b1;
    end else if (consume) begin
      byte_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (consume && is_term) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      flags_r.alive      <= '1;
      flags_r.phase      <= PH_SEARCH;
      flags_r.user_seen  <= 1'b0;
      flags_r.wants_seen <= 1'b0;
    end else begin
      byte_vld_r  <= byte_vld_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (in_valid && !in_stall) begin
      byte_r <= in_path_byte;
    end
    if (consume && is_term) begin
      out_kind_r <= kind;
      out_len_r  <= 6'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_kind  = out_kind_r;
  assign out_name_length = out_len_r;

endmodule

`default_nettype wire

// File: sim/sensitive_path_classifier_tb.sv
// Self-checking testbench for sensitive_path_classifier: streams file paths byte by byte
// and checks every classification against a predictor of the path scan kept in this file.
// Depends on spc_pkg and the RTL of sensitive_path_classifier.
`default_nettype none

module sensitive_path_classifier_tb;
  import spc_pkg::*;

  localparam int MAX_CHARS   = 63;
  localparam int START_LIMIT = 40;

  typedef enum int {
    PID_SEARCH, PID_SEEN1, PID_SEEN2, PID_SEEN3, PID_SEEN4, PID_MAPS, PID_DEAD
  } pid_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] length;
  } verdict_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_path_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_match_kind;
  logic [5:0] out_name_length;

  verdict_t   pending_verdicts[$];
  logic [7:0] path_chars[$];
  int         bytes_sent;
  int         mismatches;
  bit         idle_on;

  // Predicted scan state of the path currently being received.
  int         kept_count;
  logic [N_PREFIX-1:0] prefix_live;
  logic [7:0] tail_chars[WIN_DEPTH];
  pid_phase_t pid_phase;
  bit         user_dir_seen;
  bit         wants_dir_seen;

  sensitive_path_classifier #(
    .MAX_NAME_CHARS(MAX_CHARS),
    .SUBSTRING_START_LIMIT(START_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_path_byte(in_path_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match_kind(out_match_kind),
    .out_name_length(out_name_length)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic string prefix_text(int idx);
    case (idx)
      PX_PROC:    return "/proc/";
      PX_CRON:    return "/etc/cron";
      PX_ATJOBS:  return "/var/spool/cron/atjobs/";
      PX_ATSPOOL: return "/var/spool/cron/atspool/";
      PX_AT:      return "/var/spool/at/";
      PX_ETCSYS:  return "/etc/systemd/system/";
      PX_LIBSYS:  return "/lib/systemd/system/";
      PX_USRSYS:  return "/usr/lib/systemd/system/";
      PX_SUDO:    return "/etc/sudoers";
      PX_SHADOW:  return "/etc/shadow";
      default:    return "/etc/passwd";
    endcase
  endfunction

  function automatic void scan_clear();
    kept_count     = 0;
    prefix_live    = '1;
    pid_phase      = PID_SEARCH;
    user_dir_seen  = 1'b0;
    wants_dir_seen = 1'b0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      tail_chars[i] = 8'h00;
    end
  endfunction

  function automatic bit tail_is(string t);
    int n;
    n = t.len();
    if (n > WIN_DEPTH || kept_count < n) begin
      return 1'b0;
    end
    for (int j = 0; j < n; j++) begin
      if (tail_chars[n-1-j] != t[j]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit prefix_ok(int idx);
    string s;
    s = prefix_text(idx);
    return prefix_live[idx] && kept_count >= s.len();
  endfunction

  function automatic bit early_substring(string t);
    return tail_is(t) && (kept_count - t.len()) <= START_LIMIT;
  endfunction

  function automatic kind_t classify_path();
    bit proc_ok;
    bit unit_dir;
    proc_ok = prefix_ok(PX_PROC);
    if (proc_ok && pid_phase == PID_MAPS) begin
      return KIND_MAPS;
    end
    if (proc_ok && pid_phase == PID_SEEN4 && tail_is("/mem")) begin
      return KIND_MEM;
    end
    if (prefix_ok(PX_ATJOBS) || prefix_ok(PX_ATSPOOL) || prefix_ok(PX_AT)) begin
      return KIND_AT;
    end
    unit_dir = prefix_ok(PX_ETCSYS) || prefix_ok(PX_LIBSYS) || prefix_ok(PX_USRSYS) ||
               user_dir_seen || (wants_dir_seen && kept_count >= WANTS_MIN_KEPT);
    if (prefix_ok(PX_CRON) || (tail_is(".timer") && unit_dir) || prefix_ok(PX_SUDO) ||
        prefix_ok(PX_SHADOW) || prefix_ok(PX_PASSWD)) begin
      return KIND_CRON;
    end
    return KIND_NONE;
  endfunction

  function automatic void path_step(input logic [7:0] c, output bit emit, output verdict_t v);
    int    pos;
    string s;
    emit = 1'b0;
    v    = '0;
    if (c == CHAR_NUL) begin
      emit     = 1'b1;
      v.kind   = classify_path();
      v.length = kept_count[5:0];
      scan_clear();
      return;
    end
    if (kept_count >= MAX_CHARS) begin
      return;
    end
    pos = kept_count;
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      tail_chars[i] = tail_chars[i-1];
    end
    tail_chars[0] = c;
    for (int i = 0; i < N_PREFIX; i++) begin
      s = prefix_text(i);
      if (pos < s.len() && s[pos] != c) begin
        prefix_live[i] = 1'b0;
      end
    end
    kept_count = pos + 1;
    case (pid_phase)
      PID_SEARCH: begin
        if (pos >= PID_SLASH_FIRST && pos <= PID_SLASH_LAST && c == CHAR_SLASH) begin
          pid_phase = PID_SEEN1;
        end else if (pos >= PID_SLASH_LAST) begin
          pid_phase = PID_DEAD;
        end
      end
      PID_SEEN1: pid_phase = PID_SEEN2;
      PID_SEEN2: pid_phase = PID_SEEN3;
      PID_SEEN3: pid_phase = PID_SEEN4;
      PID_SEEN4: pid_phase = tail_is("/maps") ? PID_MAPS : PID_DEAD;
      default: ;
    endcase
    if (early_substring("/.config/systemd/user/")) begin
      user_dir_seen = 1'b1;
    end
    if (early_substring("timers.target.wants/")) begin
      wants_dir_seen = 1'b1;
    end
  endfunction

  // Path building helpers; the path is collected in path_chars without its terminator.
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      path_chars.push_back(s[i]);
    end
  endfunction

  function automatic void add_word(int n);
    for (int i = 0; i < n; i++) begin
      path_chars.push_back(8'($urandom_range(97, 122)));
    end
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) begin
      path_chars.push_back(8'($urandom_range(48, 57)));
    end
  endfunction

  function automatic void add_noise(int n);
    for (int i = 0; i < n; i++) begin
      path_chars.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void make_random_path();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: begin
        add_text("/proc/");
        add_digits($urandom_range(1, 14));
        case ($urandom_range(0, 6))
          0, 1: add_text("/maps");
          2, 3: add_text("/mem");
          4:    add_text("/memx");
          5:    add_text("/mapsz");
          default: add_text("/stat");
        endcase
      end
      2: begin
        case ($urandom_range(0, 6))
          0: add_text("/etc/cron.d/");
          1: add_text("/etc/crontab");
          2: add_text("/etc/sudoers");
          3: add_text("/etc/shadow");
          4: add_text("/etc/passwd");
          5: add_text("/etc/passw");
          default: add_text("/etc/hosts");
        endcase
        add_word($urandom_range(0, 6));
      end
      3: begin
        case ($urandom_range(0, 3))
          0: add_text("/var/spool/cron/atjobs/");
          1: add_text("/var/spool/cron/atspool/");
          2: add_text("/var/spool/at/");
          default: add_text("/var/spool/cron/at");
        endcase
        add_word($urandom_range(0, 10));
      end
      4: begin
        case ($urandom_range(0, 2))
          0: add_text("/etc/systemd/system/");
          1: add_text("/lib/systemd/system/");
          default: add_text("/usr/lib/systemd/system/");
        endcase
        add_word($urandom_range(1, 40));
        if ($urandom_range(0, 3) != 0) begin
          add_text(".timer");
        end
      end
      5: begin
        add_text("/home/");
        add_word($urandom_range(1, 36));
        add_text("/.config/systemd/user/");
        add_word($urandom_range(1, 8));
        if ($urandom_range(0, 3) != 0) begin
          add_text(".timer");
        end
      end
      6: begin
        add_text("/");
        add_word($urandom_range(0, 40));
        add_text("/timers.target.wants/");
        add_word($urandom_range(1, 8));
        if ($urandom_range(0, 3) != 0) begin
          add_text(".timer");
        end
      end
      default: begin
        add_noise($urandom_range(0, 72));
      end
    endcase
    // A share of the paths is corrupted at one random place.
    if (path_chars.size() > 0 && $urandom_range(0, 7) == 0) begin
      path_chars[$urandom_range(0, path_chars.size() - 1)] = 8'($urandom_range(1, 255));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    bit       emit;
    verdict_t v;
    in_valid     <= 1'b1;
    in_path_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
    path_step(b, emit, v);
    if (emit) begin
      pending_verdicts.push_back(v);
    end
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_path();
    foreach (path_chars[i]) begin
      send_byte(path_chars[i]);
    end
    send_byte(CHAR_NUL);
    path_chars.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_path();
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_text("");
    send_text("/proc/1234/maps");
    send_text("/proc/1/maps");
    send_text("/proc/123456789012/mem");
    send_text("/proc/1234567890123/mem");
    send_text("/proc/42/memx");
    send_text("/proc/42/mapsfoo");
    send_text("/proc/self/mem");
    send_text("/etc/crontab");
    send_text("/etc/sudoers.d/x");
    send_text("/etc/shadow");
    send_text("/etc/passwd");
    send_text("/etc/passw");
    send_text("/var/spool/cron/atjobs/a1");
    send_text("/var/spool/cron/atspool/x");
    send_text("/var/spool/at/j");
    send_text("/etc/systemd/system/foo.timer");
    send_text("/usr/lib/systemd/system/b.timer");
    send_text("/home/u/.config/systemd/user/x.timer");
    send_text("/timers.target.wants/a.timer");
    send_text("/timers.target.wants/ab.timer");
    // A timer name cut short by the length limit still ends in the suffix.
    add_text("/lib/systemd/system/");
    repeat (37) path_chars.push_back("a");
    add_text(".timertail");
    send_path();
    // An overlong path carrying the extreme byte values.
    path_chars.push_back(8'hFF);
    path_chars.push_back(8'h80);
    path_chars.push_back(8'h7F);
    path_chars.push_back(8'h01);
    add_noise(76);
    send_path();
  endtask

  task automatic test_random_paths(int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      make_random_path();
      send_path();
    end
  endtask

  task automatic test_drain_pause();
    test_random_paths(150);
    in_valid <= 1'b0;
    wait_drained();
    test_random_paths(150);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_paths(300);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no path pending: match_kind %0d name_length %0d",
               out_match_kind, out_name_length);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_match_kind !== want.kind) begin
          $error("match_kind: expected %0d, actual %0d", want.kind, out_match_kind);
          mismatches++;
        end
        if (out_name_length !== want.length) begin
          $error("name_length: expected %0d, actual %0d", want.length, out_name_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_path_byte <= 8'h00;
    idle_on      = 1'b1;
    bytes_sent   = 0;
    mismatches   = 0;
    scan_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_paths(450);
    test_drain_pause();
    test_steady_stream();

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
src/spc_pkg.sv
src/spc_classify.sv
src/sensitive_path_classifier.sv
sim/sensitive_path_classifier_tb.sv
